[rtl/bsq_pkg.sv]
// Package for the burst square wave generator: sizes, codes, channel record.
// No dependencies; every other file of the block except bsq_ram refers to it by scoped names.
`default_nettype none
package bsq_pkg;

  // Channel count and default shared period
  localparam int CHANNELS       = 3;
  localparam int DEFAULT_PERIOD = 1000;

  // Field widths
  localparam int CH_W   = 2;
  localparam int MODE_W = 2;
  localparam int FREQ_W = 26;
  localparam int CNT_W  = 32;
  localparam int TICK_W = 16;
  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_CLK_HZ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HIGH = 2'd2;

  localparam logic [FREQ_W-1:0] CLK_HZ_RST   = 26'd24000000;
  localparam logic [TICK_W-1:0] MIN_HIGH_RST = 16'd1;
  localparam logic [TICK_W-1:0] MAX_HIGH_RST = 16'd65534;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUTY    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PERIOD  = 2'd3;

  localparam logic [CNT_W-1:0]  ENDLESS   = 32'hFFFF_FFFF;
  localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;
  localparam logic [TICK_W-1:0] PERIOD_RST = TICK_W'(DEFAULT_PERIOD);

  // Per-channel state word held in the channel RAM
  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic [CNT_W-1:0]  bursts_left;
    logic [TICK_W-1:0] reload_point;
    logic              level;
    logic              running;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

  localparam chan_rec_t REC_RST = '{
    high_ticks:   MIN_HIGH_RST,
    low_ticks:    TICK_W'(DEFAULT_PERIOD - 1),
    bursts_left:  ENDLESS,
    reload_point: '0,
    level:        1'b0,
    running:      1'b1
  };

endpackage
`default_nettype wire

[rtl/bsq_in_if.sv]
// Input channel of the burst square wave generator: valid/ready plus command word.
// Depends on bsq_pkg for field widths.
`default_nettype none
interface bsq_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsq_pkg::MODE_W-1:0]    mode;
  logic [bsq_pkg::CH_W-1:0]      channel;
  logic [bsq_pkg::FREQ_W-1:0]    frequency;
  logic [bsq_pkg::CNT_W-1:0]     wave_count;
  logic [bsq_pkg::TICK_W-1:0]    high_time;
  logic [bsq_pkg::TICK_W-1:0]    period_ticks;

  modport source (output valid, mode, channel, frequency, wave_count, high_time,
                  period_ticks, input ready);
  modport sink   (input valid, mode, channel, frequency, wave_count, high_time,
                  period_ticks, output ready);
endinterface
`default_nettype wire

[rtl/bsq_out_if.sv]
// Result channel of the burst square wave generator: valid/ready plus status word.
// Depends on bsq_pkg for field widths.
`default_nettype none
interface bsq_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsq_pkg::CH_W-1:0]    out_channel;
  logic                        pin_level;
  logic [bsq_pkg::TICK_W-1:0]  compare_value;
  logic                        active;
  logic                        status;

  modport source (output valid, out_channel, pin_level, compare_value, active, status,
                  input ready);
  modport sink   (input valid, out_channel, pin_level, compare_value, active, status,
                  output ready);
endinterface
`default_nettype wire

[rtl/bsq_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on bsq_pkg for field widths.
`default_nettype none
interface bsq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bsq_pkg::CFG_IDX_W-1:0]   index;
  logic [bsq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/bsq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/bsq_div.sv]
// Restoring divider, one quotient bit per cycle, for counter clock / frequency.
// Depends on bsq_pkg for the operand width.
`default_nettype none
module bsq_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bsq_pkg::FREQ_W-1:0]  dividend_i,
  input  wire logic [bsq_pkg::FREQ_W-1:0]  divisor_i,
  output      logic                        done_o,
  output      logic [bsq_pkg::FREQ_W-1:0]  quot_o
);

  localparam int W      = bsq_pkg::FREQ_W;
  localparam int STEP_W = $clog2(W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      quo_q, quo_d;
  logic [W-1:0]      dsr_q, dsr_d;
  logic [W:0]        trial;
  logic [W:0]        diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

[rtl/burst_square_wave_generator.sv]
// Burst square wave generator: three compare-toggle channels whose state sits in a
// small RAM. Items are taken one at a time. A compare event, set duty or set period
// goes from acceptance to result through accept and RAM read, read data, then update
// and write back. A start command with nonzero frequency on a valid channel adds a
// divide step: the period comes from a serial divider that resolves one quotient bit
// per cycle. A waiting result holds the update stage until it is taken, while the
// next word is already accepted. Channel state after reset reads as its reset value
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module burst_square_wave_generator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bsq_in_if.sink      in_i,
  bsq_out_if.source   out_o,
  bsq_cfg_if.sink     cfg_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  localparam int TW = bsq_pkg::TICK_W;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [bsq_pkg::FREQ_W-1:0] clk_hz_q;
  logic [TW-1:0]              min_high_q;
  logic [TW-1:0]              max_high_q;
  logic [TW-1:0]              period_q, period_d;

  // captured input word
  logic [bsq_pkg::MODE_W-1:0] mode_q;
  logic [bsq_pkg::CH_W-1:0]   ch_q;
  logic                       ch_ok_q;
  logic [bsq_pkg::FREQ_W-1:0] freq_q;
  logic [bsq_pkg::CNT_W-1:0]  wcount_q;
  logic [TW-1:0]              hreq_q;
  logic [TW-1:0]              preq_q;

  logic [bsq_pkg::CHANNELS-1:0] written_q;

  logic                       in_fire;
  logic                       ch_ok_in;
  logic [3:0]                 ch_wide_in;
  logic [3:0]                 ch_wide_q;
  logic [bsq_pkg::CH_AW-1:0]  raddr;
  logic [bsq_pkg::CH_AW-1:0]  addr_q;
  logic [bsq_pkg::REC_W-1:0]  rdata;

  logic                       need_div;
  logic                       div_start;
  logic                       div_done;
  logic [bsq_pkg::FREQ_W-1:0] quot;

  bsq_pkg::chan_rec_t cur_rec;
  bsq_pkg::chan_rec_t nxt_rec;
  logic               status_c;
  logic [TW-1:0]      p_sat;
  logic [TW-1:0]      h_new;
  logic               upd_fire;

  // result register
  logic                      out_valid_q;
  logic [bsq_pkg::CH_W-1:0]  out_ch_q;
  logic                      out_level_q;
  logic [TW-1:0]             out_cmp_q;
  logic                      out_active_q;
  logic                      out_status_q;

  // input handshake and channel address
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign ch_wide_in = 4'(in_i.channel);
  assign ch_ok_in   = (ch_wide_in < 4'(bsq_pkg::CHANNELS));
  assign raddr      = ch_wide_in[bsq_pkg::CH_AW-1:0];
  assign ch_wide_q  = 4'(ch_q);
  assign addr_q     = ch_wide_q[bsq_pkg::CH_AW-1:0];

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q   <= bsq_pkg::CLK_HZ_RST;
      min_high_q <= bsq_pkg::MIN_HIGH_RST;
      max_high_q <= bsq_pkg::MAX_HIGH_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bsq_pkg::REG_CLK_HZ:   clk_hz_q   <= cfg_i.data;
        bsq_pkg::REG_MIN_HIGH: min_high_q <= cfg_i.data[TW-1:0];
        bsq_pkg::REG_MAX_HIGH: max_high_q <= cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= in_i.mode;
      ch_q     <= in_i.channel;
      ch_ok_q  <= ch_ok_in;
      freq_q   <= in_i.frequency;
      wcount_q <= in_i.wave_count;
      hreq_q   <= in_i.high_time;
      preq_q   <= in_i.period_ticks;
    end
  end

  // channel state RAM, read at accept, written back at update
  bsq_ram #(
    .WIDTH (bsq_pkg::REC_W),
    .DEPTH (bsq_pkg::CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (upd_fire && ch_ok_q),
    .waddr_i (addr_q),
    .wdata_i (nxt_rec),
    .re_i    (in_fire && ch_ok_in),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // period divider
  assign need_div  = (mode_q == bsq_pkg::MODE_START) && (freq_q != '0) && ch_ok_q;
  assign div_start = (state_q == S_READ) && need_div;

  bsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_hz_q),
    .divisor_i  (freq_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // unwritten entries read as their reset value
  assign cur_rec = written_q[addr_q] ? bsq_pkg::chan_rec_t'(rdata) : bsq_pkg::REC_RST;
  assign p_sat   = (|quot[bsq_pkg::FREQ_W-1:TW]) ? bsq_pkg::TICK_MAX : quot[TW-1:0];

  // record update per mode
  always_comb begin
    nxt_rec  = cur_rec;
    period_d = period_q;
    status_c = 1'b0;
    h_new    = hreq_q;
    unique case (mode_q)
      bsq_pkg::MODE_COMPARE: begin
        if (ch_ok_q && cur_rec.running) begin
          nxt_rec.level = ~cur_rec.level;
          if (!cur_rec.level) begin
            nxt_rec.reload_point = cur_rec.reload_point + cur_rec.high_ticks;
          end else begin
            nxt_rec.reload_point = cur_rec.reload_point + cur_rec.low_ticks;
            if (cur_rec.bursts_left != bsq_pkg::ENDLESS) begin
              if (cur_rec.bursts_left != '0) begin
                nxt_rec.bursts_left = cur_rec.bursts_left - 1'b1;
                if (cur_rec.bursts_left == bsq_pkg::CNT_W'(1)) begin
                  nxt_rec.running = 1'b0;
                end
              end else begin
                nxt_rec.running = 1'b0;
              end
            end
          end
        end
      end
      bsq_pkg::MODE_START: begin
        if (freq_q == '0) begin
          status_c = 1'b1;
        end else if (ch_ok_q) begin
          h_new               = {1'b0, p_sat[TW-1:1]};
          period_d            = p_sat;
          nxt_rec.high_ticks  = h_new;
          nxt_rec.low_ticks   = p_sat - h_new;
          nxt_rec.bursts_left = wcount_q;
          nxt_rec.running     = 1'b1;
        end
      end
      bsq_pkg::MODE_DUTY: begin
        // clamp to max first, then min wins
        if (hreq_q > max_high_q) begin
          h_new = max_high_q;
        end
        if (h_new < min_high_q) begin
          h_new = min_high_q;
        end
        if (ch_ok_q) begin
          nxt_rec.high_ticks = h_new;
          nxt_rec.low_ticks  = period_q - h_new;
        end
      end
      bsq_pkg::MODE_PERIOD: begin
        period_d = preq_q;
      end
      default: ;
    endcase
  end

  assign upd_fire = (state_q == S_UPD) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire)  state_d = S_READ;
      S_READ: state_d = need_div ? S_DIV : S_UPD;
      S_DIV:  if (div_done) state_d = S_UPD;
      S_UPD:  if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= bsq_pkg::PERIOD_RST;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_fire) begin
        period_q    <= period_d;
        out_valid_q <= 1'b1;
        if (ch_ok_q) begin
          written_q[addr_q] <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_ch_q     <= ch_q;
      out_level_q  <= ch_ok_q & nxt_rec.level;
      out_cmp_q    <= ch_ok_q ? nxt_rec.reload_point : '0;
      out_active_q <= ch_ok_q & nxt_rec.running;
      out_status_q <= ch_ok_q & status_c;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_channel   = out_ch_q;
  assign out_o.pin_level     = out_level_q;
  assign out_o.compare_value = out_cmp_q;
  assign out_o.active        = out_active_q;
  assign out_o.status        = out_status_q;

endmodule
`default_nettype wire
